>>> sv/pll_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise-linear lookup package
// Shared widths, opcodes and status codes of the lookup core.
// ----------------------------------------------------------------------------
package pll_pkg;

	localparam int unsigned DATA_W      = 32;
	localparam int unsigned OP_W        = 2;
	localparam int unsigned STATUS_W    = 2;
	localparam int unsigned DEF_MAX_BP  = 16;
	localparam int unsigned DEF_FRAC    = 16;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	typedef struct packed {
		logic [OP_W-1:0]          opcode;
		logic signed [DATA_W-1:0] key_x;
		logic signed [DATA_W-1:0] key_y;
		logic signed [DATA_W-1:0] query_value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic                     out_of_range;
		logic [STATUS_W-1:0]      status;
	} rsp_t;

endpackage

>>> sv/pll_if.sv
// ----------------------------------------------------------------------------
// Piecewise-linear lookup channel
// Valid/ready channel carrying one payload struct.
// ----------------------------------------------------------------------------
interface pll_if #(
	parameter type payload_t = logic
) (
	input logic clk
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/pll_div.sv
// ----------------------------------------------------------------------------
// Piecewise-linear lookup divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pll_div #(
	parameter int unsigned NUM_W = 48,
	parameter int unsigned DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quot_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q[DEN_W-1:0], quot_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			if (!diff[DEN_W]) begin
				rem_q  <= diff;
				quot_q <= {quot_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial;
				quot_q <= {quot_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quot = quot_q;
endmodule

>>> sv/pll_ctrl.sv
// ----------------------------------------------------------------------------
// Piecewise-linear lookup sequencer
// Owns the breakpoint memory; runs clear, sorted insert and lookup.
// ----------------------------------------------------------------------------
module pll_ctrl #(
	parameter int unsigned MAX_BREAKPOINTS = pll_pkg::DEF_MAX_BP,
	parameter int unsigned FRAC_BITS       = pll_pkg::DEF_FRAC
) (
	input  logic clk,
	input  logic arst_n,
	pll_if.sink   req,
	pll_if.source rsp
);
	localparam int unsigned DW    = pll_pkg::DATA_W;
	localparam int unsigned AW    = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
	localparam int unsigned CW    = $clog2(MAX_BREAKPOINTS + 1);
	localparam int unsigned NUM_W = DW + FRAC_BITS;
	localparam int unsigned RW    = (FRAC_BITS > 0) ? FRAC_BITS : 1;
	localparam int unsigned PW    = RW + DW + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_INS_RD, S_INS_CMP, S_LK_RD, S_LK_CMP, S_LK_HI,
		S_DIV, S_MUL, S_ADD, S_OUT
	} state_t;

	state_t state_q;
	logic signed [DW-1:0] mem_x [MAX_BREAKPOINTS];
	logic signed [DW-1:0] mem_y [MAX_BREAKPOINTS];
	logic signed [DW-1:0] rd_x_q, rd_y_q;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic signed [DW-1:0] wr_x, wr_y;

	logic [CW-1:0]        count_q;
	logic [CW-1:0]        pos_q;
	logic signed [DW-1:0] kx_q, ky_q, qv_q;
	logic signed [DW-1:0] xlo_q, ylo_q;
	logic [DW-1:0]        span_q;
	logic signed [DW:0]   dy_q;
	logic [RW-1:0]        ratio_q;
	logic [PW-1:0]        prod_q;
	pll_pkg::rsp_t        rsp_q;
	logic                 rsp_valid_q;
	logic                 div_start;
	logic                 div_done;
	logic [NUM_W-1:0]     div_quot;
	logic [DW:0]          mag;
	logic [DW-1:0]        dx;

	pll_div #(.NUM_W(NUM_W), .DEN_W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(NUM_W'(dx) << FRAC_BITS), .den(span_q), .done(div_done), .quot(div_quot)
	);

	assign dx  = DW'(qv_q - xlo_q);
	assign mag = dy_q[DW] ? (DW+1)'(0) - dy_q : dy_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[wr_addr] <= wr_x;
			mem_y[wr_addr] <= wr_y;
		end
		rd_x_q <= mem_x[rd_addr];
		rd_y_q <= mem_y[rd_addr];
	end

	always_comb begin
		rd_addr   = AW'(pos_q - 1'b1);
		wr_en     = 1'b0;
		wr_addr   = pos_q[AW-1:0];
		wr_x      = kx_q;
		wr_y      = ky_q;
		div_start = 1'b0;
		unique case (state_q)
			S_LK_RD, S_LK_CMP: rd_addr = pos_q[AW-1:0];
			S_INS_CMP: begin
				wr_en = 1'b1;
				if (pos_q != '0 && rd_x_q > kx_q) begin
					wr_x = rd_x_q;
					wr_y = rd_y_q;
				end
			end
			S_LK_HI: div_start = (span_q != '0);
			default: ;
		endcase
	end

	assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			pos_q       <= '0;
		end else begin
			if (rsp.valid && rsp.ready) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (req.valid && req.ready) begin
					kx_q  <= req.data.key_x;
					ky_q  <= req.data.key_y;
					qv_q  <= req.data.query_value;
					unique case (req.data.opcode)
						pll_pkg::OP_CLEAR: begin
							rsp_q   <= '0;
							count_q <= '0;
							state_q <= S_OUT;
						end
						pll_pkg::OP_INSERT: begin
							pos_q <= count_q;
							if (count_q >= CW'(MAX_BREAKPOINTS)) begin
								rsp_q   <= '{result_value: '0, out_of_range: 1'b0,
									status: pll_pkg::ST_FULL};
								state_q <= S_OUT;
							end else begin
								rsp_q   <= '0;
								state_q <= S_INS_RD;
							end
						end
						pll_pkg::OP_LOOKUP: begin
							pos_q <= '0;
							if (count_q == '0) begin
								rsp_q   <= '{result_value: req.data.query_value,
									out_of_range: 1'b1, status: pll_pkg::ST_EMPTY};
								state_q <= S_OUT;
							end else begin
								rsp_q   <= '0;
								state_q <= S_LK_RD;
							end
						end
						default: begin
							rsp_q   <= '0;
							state_q <= S_OUT;
						end
					endcase
				end
				S_INS_RD: state_q <= S_INS_CMP;
				S_INS_CMP: begin
					if (pos_q != '0 && rd_x_q > kx_q) begin
						pos_q   <= pos_q - 1'b1;
						state_q <= S_INS_RD;
					end else begin
						count_q <= count_q + 1'b1;
						state_q <= S_OUT;
					end
				end
				S_LK_RD: state_q <= S_LK_CMP;
				S_LK_CMP: begin
					if (pos_q == '0 && qv_q < rd_x_q) begin
						rsp_q.result_value <= qv_q;
						rsp_q.out_of_range <= 1'b1;
						state_q            <= S_OUT;
					end else if (pos_q == count_q - 1'b1 && qv_q > rd_x_q) begin
						rsp_q.result_value <= qv_q;
						rsp_q.out_of_range <= 1'b1;
						state_q            <= S_OUT;
					end else if (pos_q == count_q - 1'b1 && qv_q == rd_x_q) begin
						rsp_q.result_value <= rd_y_q;
						state_q            <= S_OUT;
					end else if (pos_q != count_q - 1'b1 && rd_x_q <= qv_q) begin
						xlo_q   <= rd_x_q;
						ylo_q   <= rd_y_q;
						pos_q   <= pos_q + 1'b1;
						state_q <= S_LK_RD;
					end else begin
						span_q  <= DW'(rd_x_q - xlo_q);
						dy_q    <= (DW+1)'(rd_y_q) - (DW+1)'(ylo_q);
						state_q <= S_LK_HI;
					end
				end
				S_LK_HI: begin
					if (span_q == '0) begin
						rsp_q.result_value <= ylo_q;
						state_q            <= S_OUT;
					end else state_q <= S_DIV;
				end
				S_DIV: if (div_done) begin
					ratio_q <= RW'(div_quot);
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= PW'(ratio_q) * PW'(mag);
					state_q <= S_ADD;
				end
				S_ADD: begin
					rsp_q.result_value <= dy_q[DW]
						? ylo_q - DW'(prod_q >> FRAC_BITS)
						: ylo_q + DW'(prod_q >> FRAC_BITS);
					state_q <= S_OUT;
				end
				S_OUT: begin
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> sv/piecewise_linear_lookup_core.sv
// ----------------------------------------------------------------------------
// Piecewise-linear lookup core
// Sorted breakpoint table with clear, insert and interpolating lookup.
// ----------------------------------------------------------------------------
// req carries opcode, key_x, key_y, query_value; rsp carries result_value,
// out_of_range and status, one transaction per request.
// A request is taken only when the core is idle and no result is pending, so
// one transaction is in flight at a time. Clear and unused opcodes go
// straight to the result. Insert shifts larger entries up one at a time
// until the slot for key_x is found; an insert into a full table answers
// ST_FULL without a write. Lookup scans the breakpoints in order through
// the memory read port; interpolation then runs the bit-serial divider,
// a multiply and an add.
// The result register holds until rsp.ready; a stalled receiver stalls req.
// Reset empties the table at once; breakpoint memory contents are not reset.
module piecewise_linear_lookup_core #(
	parameter int unsigned MAX_BREAKPOINTS = pll_pkg::DEF_MAX_BP,
	parameter int unsigned FRAC_BITS       = pll_pkg::DEF_FRAC
) (
	input logic clk,
	input logic arst_n,
	pll_if.sink   req,
	pll_if.source rsp
);
	pll_ctrl #(.MAX_BREAKPOINTS(MAX_BREAKPOINTS), .FRAC_BITS(FRAC_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("result dropped under stall");
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("request taken while result pending");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status == pll_pkg::ST_EMPTY |-> rsp.data.out_of_range)
		else $error("empty lookup not flagged");
endmodule
